>>> hdl/b64e_pkg.sv
// Shared types, constants and the sextet-to-character function for the
// Base64 stream encoder. No dependencies.
package b64e_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned CharW  = 7;
  localparam int unsigned SextW  = 6;
  localparam int unsigned GroupN = 4;
  localparam int unsigned CountW = 3;   // holds 0 to GroupN characters
  localparam int unsigned IdxW   = 2;   // selects one of GroupN characters

  // Configuration register indexes.
  localparam logic CFG_URL_SAFE     = 1'b0;
  localparam logic CFG_SKIP_PADDING = 1'b1;

  // Character codes.
  localparam logic [CharW-1:0] CHAR_PAD   = 7'h3D;  // '='
  localparam logic [CharW-1:0] CHAR_UPPER = 7'h41;  // 'A'
  localparam logic [CharW-1:0] CHAR_LOWER = 7'h61;  // 'a'
  localparam logic [CharW-1:0] CHAR_DIGIT = 7'h30;  // '0'
  localparam logic [CharW-1:0] CHAR_PLUS  = 7'h2B;  // '+'
  localparam logic [CharW-1:0] CHAR_SLASH = 7'h2F;  // '/'
  localparam logic [CharW-1:0] CHAR_MINUS = 7'h2D;  // '-'
  localparam logic [CharW-1:0] CHAR_UNDER = 7'h5F;  // '_'

  // Characters of one item, first character in element 0.
  typedef struct packed {
    logic [GroupN-1:0][CharW-1:0] chars;
    logic [CountW-1:0]            count;
    logic                         msg_end;
  } b64e_group_t;

  // Map a six-bit value to its alphabet character.
  function automatic logic [CharW-1:0] sextet_char(input logic [SextW-1:0] v,
                                                   input logic url_safe);
    logic [CharW-1:0] c;
    logic [CharW-1:0] v7;
    begin
      v7 = {1'b0, v};
      if (v < 6'd26) begin
        c = CHAR_UPPER + v7;
      end else if (v < 6'd52) begin
        c = CHAR_LOWER + (v7 - 7'd26);
      end else if (v < 6'd62) begin
        c = CHAR_DIGIT + (v7 - 7'd52);
      end else if (v == 6'd62) begin
        c = url_safe ? CHAR_MINUS : CHAR_PLUS;
      end else begin
        c = url_safe ? CHAR_UNDER : CHAR_SLASH;
      end
      return c;
    end
  endfunction

endpackage

>>> hdl/b64e_group.sv
// Combinational group former: turns one input beat and the pending bytes
// into up to four characters. Depends on b64e_pkg.
module b64e_group (
  input  logic [b64e_pkg::ByteW-1:0] pend0,
  input  logic [b64e_pkg::ByteW-1:0] pend1,
  input  logic [1:0]                 pend_cnt,
  input  logic [b64e_pkg::ByteW-1:0] data_byte,
  input  logic                       byte_valid,
  input  logic                       end_of_message,
  input  logic                       url_safe,
  input  logic                       skip_padding,
  output logic                       full,
  output b64e_pkg::b64e_group_t      group
);
  import b64e_pkg::*;

  logic [1:0]        cnt_after;
  logic [ByteW-1:0]  b1;
  logic [ByteW-1:0]  b2;
  logic [ByteW-1:0]  b3;
  logic [SextW-1:0]  s0;
  logic [SextW-1:0]  s1;
  logic [SextW-1:0]  s2;
  logic [SextW-1:0]  s3;
  logic              pad2;
  logic              pad3;
  logic [CountW-1:0] grp_cnt;

  // A third byte completes a group.
  assign full      = byte_valid && (pend_cnt == 2'd2);
  assign cnt_after = pend_cnt + {1'b0, byte_valid};

  // Select the bytes of the group and which tail positions are padding.
  always_comb begin
    b1      = (byte_valid && pend_cnt == 2'd0) ? data_byte : pend0;
    b2      = (byte_valid && pend_cnt == 2'd1) ? data_byte : pend1;
    b3      = data_byte;
    pad2    = 1'b0;
    pad3    = 1'b0;
    grp_cnt = '0;
    if (full) begin
      b1 = pend0;
      b2 = pend1;
      grp_cnt = CountW'(GroupN);
    end else if (end_of_message && cnt_after == 2'd1) begin
      b2   = '0;
      b3   = '0;
      pad2 = 1'b1;
      pad3 = 1'b1;
      grp_cnt = skip_padding ? 3'd2 : CountW'(GroupN);
    end else if (end_of_message && cnt_after == 2'd2) begin
      b3   = '0;
      pad3 = 1'b1;
      grp_cnt = skip_padding ? 3'd3 : CountW'(GroupN);
    end
  end

  // Split into sextets and map to characters.
  assign s0 = b1[7:2];
  assign s1 = {b1[1:0], b2[7:4]};
  assign s2 = {b2[3:0], b3[7:6]};
  assign s3 = b3[5:0];

  always_comb begin
    group.chars[0] = sextet_char(s0, url_safe);
    group.chars[1] = sextet_char(s1, url_safe);
    group.chars[2] = pad2 ? CHAR_PAD : sextet_char(s2, url_safe);
    group.chars[3] = pad3 ? CHAR_PAD : sextet_char(s3, url_safe);
    group.count    = grp_cnt;
    group.msg_end  = end_of_message;
  end

endmodule

>>> hdl/base64_stream_encoder.sv
// Top level of the Base64 stream encoder: pending-byte state, group
// buffer and character output register. Depends on b64e_pkg, b64e_group.
//
//   Channel  Ports                                        Direction
//   in       in_valid/in_ready, in_data_byte,             sink
//            in_byte_valid, in_end_of_message
//   out      out_valid/out_ready, out_character,          source
//            out_run_end, out_message_end
//   cfg      cfg_valid/cfg_ready, cfg_index, cfg_data     sink, always ready
//
// The characters of an input beat leave one per cycle from the output
// register while out_ready is high. The group buffer holds the next
// beat's characters while the output register drains, so input is taken
// on the cycle the last character of the buffered group moves out.
// Reset clears the pending count, both valids and the configuration.
module base64_stream_encoder (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [b64e_pkg::ByteW-1:0]  in_data_byte,
  input  logic                        in_byte_valid,
  input  logic                        in_end_of_message,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [b64e_pkg::CharW-1:0]  out_character,
  output logic                        out_run_end,
  output logic                        out_message_end,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic                        cfg_index,
  input  logic                        cfg_data
);
  import b64e_pkg::*;

  logic               url_safe_r;
  logic               skip_padding_r;
  logic [ByteW-1:0]   pend_r [2];
  logic [1:0]         pend_cnt_r;
  logic [1:0]         pend_cnt_nxt;
  logic               full;
  b64e_group_t        group;
  b64e_group_t        grp_r;
  logic               grp_valid_r;
  logic [IdxW-1:0]    grp_idx_r;
  logic               grp_last;
  logic               out_load;
  logic               in_fire;
  logic               out_valid_r;
  logic [CharW-1:0]   out_char_r;
  logic               out_run_end_r;
  logic               out_msg_end_r;

  // Configuration registers.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      url_safe_r     <= 1'b0;
      skip_padding_r <= 1'b0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_URL_SAFE:     url_safe_r     <= cfg_data;
        CFG_SKIP_PADDING: skip_padding_r <= cfg_data;
        default:          ;
      endcase
    end
  end

  // Group formation from the beat and the pending bytes.
  b64e_group u_group (
    .pend0          (pend_r[0]),
    .pend1          (pend_r[1]),
    .pend_cnt       (pend_cnt_r),
    .data_byte      (in_data_byte),
    .byte_valid     (in_byte_valid),
    .end_of_message (in_end_of_message),
    .url_safe       (url_safe_r),
    .skip_padding   (skip_padding_r),
    .full           (full),
    .group          (group)
  );

  // Handshake between the group buffer and the output register.
  assign out_load = grp_valid_r && (!out_valid_r || out_ready);
  assign grp_last = ({1'b0, grp_idx_r} == (grp_r.count - 3'd1));
  assign in_ready = !grp_valid_r || (out_load && grp_last);
  assign in_fire  = in_valid && in_ready;

  // Pending state: an end mark or a completed group always empties it.
  assign pend_cnt_nxt = (full || in_end_of_message) ? 2'd0
                                                    : pend_cnt_r + {1'b0, in_byte_valid};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_cnt_r <= 2'd0;
    end else if (in_fire) begin
      pend_cnt_r <= pend_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && in_byte_valid && !full) begin
      pend_r[pend_cnt_r[0]] <= in_data_byte;
    end
  end

  // Group buffer: holds the characters of one beat until all have moved out.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grp_valid_r <= 1'b0;
      grp_idx_r   <= '0;
    end else if (in_fire && group.count != '0) begin
      grp_valid_r <= 1'b1;
      grp_idx_r   <= '0;
    end else if (out_load && grp_last) begin
      grp_valid_r <= 1'b0;
    end else if (out_load) begin
      grp_idx_r <= grp_idx_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && group.count != '0) begin
      grp_r <= group;
    end
  end

  // Output register: one character beat per cycle while out_ready is high.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_char_r    <= grp_r.chars[grp_idx_r];
      out_run_end_r <= grp_last;
      out_msg_end_r <= grp_last && grp_r.msg_end;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_character   = out_char_r;
  assign out_run_end     = out_run_end_r;
  assign out_message_end = out_msg_end_r;

endmodule
